[rtl/psi_pkg.sv]
// Shared types, constants and arithmetic helpers of the particle store integrator.
`default_nettype none
package psi_pkg;

  localparam int unsigned StoreDepthDef = 1024;
  localparam logic [10:0] CapReset      = 11'd1024;
  localparam logic [11:0] MaxStep       = 12'd2185;
  localparam logic [15:0] MinLife       = 16'd205;
  localparam int unsigned DivW          = 31;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;
  localparam logic [31:0] Recip3        = 32'h5555_5556;
  localparam logic [31:0] Recip5        = 32'h3333_3334;

  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpSpawn = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  typedef struct packed {
    logic [15:0]       drag;
    logic [15:0]       grav;
    logic [15:0]       esz;
    logic [15:0]       sz;
    logic [15:0]       life;
    logic [15:0]       age;
    logic [3:0][15:0]  ecol;
    logic [3:0][15:0]  col;
    logic [2:0][15:0]  vel;
    logic [2:0][15:0]  pos;
  } psi_rec_t;

  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                   input int unsigned n);
    logic [63:0] mag;
    logic [63:0] r;
    mag = x[63] ? 64'(-x) : 64'(x);
    r = (mag + (64'd1 << (n - 1))) >> n;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'h7fff;
    if (v < -64'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

endpackage
`default_nettype wire

[rtl/psi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module psi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/psi_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module psi_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [psi_pkg::DivW-1:0]   dividend_i,
  input  wire logic [15:0]                divisor_i,
  output logic                            busy_o,
  output logic      [psi_pkg::DivW-1:0]   quotient_o
);
  import psi_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] quo_q;
  logic [15:0]     rem_q;
  logic [15:0]     dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [16:0]     trial;

  assign trial = {rem_q, quo_q[DivW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DivW);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_q <= 16'(trial - {1'b0, dvs_q});
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= trial[15:0];
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

[rtl/particle_store_integrator.sv]
// Particle store integrator top level: APB register, sequencer, shared multiplier and store.
// Spawn and operations that touch no entry finish in the idle state; a read passes through
// a RAM wait state and a data state. A tick walks the live particles one at a time through
// a single record RAM and a shared 32x32 multiplier: each particle gets gravity, position
// and age, with drag a series of six terms (each division by the term index done by a
// shift or a reciprocal multiply), and when the particle survives its color and size move,
// after waiting on the radix-2 divider. All particle records live in one RAM of STORE_DEPTH
// entries.
`default_nettype none
module particle_store_integrator #(
  parameter int unsigned STORE_DEPTH = psi_pkg::StoreDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [15:0] step_time_i,
  input  wire logic [9:0]  read_index_i,
  input  wire logic [47:0] spawn_position_i,
  input  wire logic [47:0] spawn_velocity_i,
  input  wire logic [47:0] spawn_life_drag_gravity_i,
  input  wire logic [63:0] spawn_color_i,
  input  wire logic [63:0] spawn_end_color_i,
  input  wire logic [31:0] spawn_sizes_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             accepted_o,
  output logic      [10:0] live_count_o,
  output logic             read_valid_o,
  output logic      [47:0] out_position_o,
  output logic      [63:0] out_color_o,
  output logic      [15:0] out_size_o,
  output logic      [15:0] out_age_o
);
  import psi_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned RW = $bits(psi_rec_t);

  typedef enum logic [4:0] {
    S_IDLE, S_RWAIT, S_RDATA, S_TWAIT, S_TLOAD, S_GRAV, S_GRAV2, S_X, S_X2,
    S_TM, S_TD, S_TR, S_TDW, S_CLAMP, S_VM, S_VM2, S_POS, S_POS2, S_AGE, S_LCHK,
    S_AD, S_LM, S_LM2, S_WB
  } state_e;

  state_e                  state_q;
  logic [10:0]             cap_q;
  logic [LW-1:0]           live_q;
  logic [LW-1:0]           i_q;
  logic [LW-1:0]           w_q;
  logic [AW-1:0]           rd_addr_q;
  logic [11:0]             dt_q;
  psi_rec_t                rec_q;
  logic signed [63:0]      prod_q;
  logic [31:0]             x_q;
  logic [DivW-1:0]         term_q;
  logic signed [33:0]      sum_q;
  logic [30:0]             dec_q;
  logic [2:0]              kk_q;
  logic [1:0]              kv_q;
  logic [2:0]              kl_q;
  logic [16:0]             a_q;

  psi_rec_t                rd_data;
  psi_rec_t                spawn_rec;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  psi_rec_t                ram_wdata;
  logic signed [31:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic                    div_start;
  logic [DivW-1:0]         div_dividend;
  logic [15:0]             div_divisor;
  logic                    div_busy;
  logic [DivW-1:0]         div_quo;
  logic [31:0]             recip;
  logic [DivW-1:0]         term_div;
  logic                    in_fire;
  logic [11:0]             dt_in;
  logic [7:0]              dt12;
  logic [16:0]             age_sum;
  logic [15:0]             lc;
  logic [15:0]             le;
  logic signed [16:0]      ldiff;
  logic signed [63:0]      lsum;
  logic [LW-1:0]           i_nxt;
  logic [LW-1:0]           w_nxt;
  logic                    keep;

  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == 1'b0) ? {21'b0, cap_q} : 32'b0;
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_o;
  assign in_fire    = in_valid_i && in_ready_o;
  assign dt_in      = (step_time_i > 16'(MaxStep)) ? MaxStep : step_time_i[11:0];
  assign dt12       = 8'((13'(dt_q) + 13'd8) >> 4);
  assign age_sum    = 17'(rec_q.age) + 17'(dt12);
  assign lc         = (kl_q[2] == 1'b0) ? rec_q.col[kl_q[1:0]] : rec_q.sz;
  assign le         = (kl_q[2] == 1'b0) ? rec_q.ecol[kl_q[1:0]] : rec_q.esz;
  assign ldiff      = $signed({1'b0, le}) - $signed({1'b0, lc});
  assign lsum       = $signed({48'b0, lc}) + rnd_shift(prod_q, 16);
  assign keep       = rec_q.age < rec_q.life;
  assign i_nxt      = i_q + 1'b1;
  assign w_nxt      = keep ? w_q + 1'b1 : w_q;

  always_comb begin
    spawn_rec      = '0;
    spawn_rec.pos  = spawn_position_i;
    spawn_rec.vel  = spawn_velocity_i;
    spawn_rec.col  = spawn_color_i;
    spawn_rec.ecol = spawn_end_color_i;
    spawn_rec.life = (spawn_life_drag_gravity_i[15:0] < MinLife) ? MinLife
                                                               : spawn_life_drag_gravity_i[15:0];
    spawn_rec.age  = 16'd0;
    spawn_rec.sz   = spawn_sizes_i[15:0];
    spawn_rec.esz  = spawn_sizes_i[31:16];
    spawn_rec.drag = spawn_life_drag_gravity_i[31:16];
    spawn_rec.grav = spawn_life_drag_gravity_i[47:32];
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w_q[AW-1:0];
    ram_wdata = rec_q;
    if (in_fire && operation_i == OpSpawn && 32'(live_q) < 32'(cap_q)
        && 32'(live_q) < STORE_DEPTH) begin
      ram_we    = 1'b1;
      ram_waddr = live_q[AW-1:0];
      ram_wdata = spawn_rec;
    end else if (state_q == S_WB && keep) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    case (kk_q) inside
      3'd3, 3'd6: recip = Recip3;
      3'd5:       recip = Recip5;
      default:    recip = '0;
    endcase
  end

  always_comb begin
    case (kk_q) inside
      3'd2:       term_div = term_q >> 1;
      3'd3, 3'd5: term_div = DivW'(prod_q >>> 32);
      3'd4:       term_div = term_q >> 2;
      3'd6:       term_div = DivW'(prod_q >>> 33);
      default:    term_div = term_q;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_GRAV: begin
        mul_a = 32'($signed(rec_q.grav));
        mul_b = {20'b0, dt_q};
      end
      S_X: begin
        mul_a = {16'b0, rec_q.drag};
        mul_b = {20'b0, dt_q};
      end
      S_TM: begin
        mul_a = {1'b0, term_q};
        mul_b = x_q;
      end
      S_TR: begin
        mul_a = {1'b0, term_q};
        mul_b = recip;
      end
      S_VM: begin
        mul_a = 32'($signed(rec_q.vel[kv_q]));
        mul_b = {1'b0, dec_q};
      end
      S_POS: begin
        mul_a = 32'($signed(rec_q.vel[kv_q]));
        mul_b = {20'b0, dt_q};
      end
      S_LM: begin
        mul_a = 32'(ldiff);
        mul_b = {15'b0, a_q};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign div_start    = (state_q == S_LCHK) && keep;
  assign div_dividend = DivW'({dt_q, 12'b0});
  assign div_divisor  = rec_q.life - rec_q.age;

  psi_ram #(.Width(RW), .Depth(STORE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr_q),
    .rdata_o (rd_data)
  );

  psi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cap_q        <= CapReset;
      live_q       <= '0;
      out_valid_o  <= 1'b0;
      i_q          <= '0;
      w_q          <= '0;
      rd_addr_q    <= '0;
      kk_q         <= '0;
      kv_q         <= '0;
      kl_q         <= '0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == 1'b0) begin
        cap_q <= pwdata[10:0];
      end
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            accepted_o     <= 1'b0;
            read_valid_o   <= 1'b0;
            out_position_o <= '0;
            out_color_o    <= '0;
            out_size_o     <= '0;
            out_age_o      <= '0;
            live_count_o   <= 11'(live_q);
            dt_q           <= dt_in;
            if (operation_i == OpTick && step_time_i != 16'd0 && live_q != '0) begin
              i_q       <= '0;
              w_q       <= '0;
              rd_addr_q <= '0;
              state_q   <= S_TWAIT;
            end else if (operation_i == OpRead && 32'(read_index_i) < 32'(live_q)) begin
              rd_addr_q <= AW'(read_index_i);
              state_q   <= S_RWAIT;
            end else begin
              if (ram_we) begin
                live_q       <= live_q + 1'b1;
                live_count_o <= 11'(live_q + 1'b1);
                accepted_o   <= 1'b1;
              end
              out_valid_o <= 1'b1;
            end
          end
        end
        S_RWAIT: state_q <= S_RDATA;
        S_RDATA: begin
          read_valid_o   <= 1'b1;
          out_position_o <= rd_data.pos;
          out_color_o    <= rd_data.col;
          out_size_o     <= rd_data.sz;
          out_age_o      <= rd_data.age;
          out_valid_o    <= 1'b1;
          state_q        <= S_IDLE;
        end
        S_TWAIT: state_q <= S_TLOAD;
        S_TLOAD: begin
          rec_q   <= rd_data;
          state_q <= S_GRAV;
        end
        S_GRAV: state_q <= S_GRAV2;
        S_GRAV2: begin
          rec_q.vel[1] <= sat16(64'($signed(rec_q.vel[1])) + rnd_shift(prod_q, 18));
          kv_q         <= '0;
          state_q      <= (rec_q.drag != 16'd0) ? S_X : S_POS;
        end
        S_X: state_q <= S_X2;
        S_X2: begin
          x_q     <= 32'(prod_q) << 2;
          term_q  <= DivW'(OneQ30);
          sum_q   <= OneQ30;
          kk_q    <= 3'd1;
          state_q <= S_TM;
        end
        S_TM: state_q <= S_TD;
        S_TD: begin
          term_q  <= DivW'(prod_q >>> 30);
          state_q <= S_TR;
        end
        S_TR: state_q <= S_TDW;
        S_TDW: begin
          term_q <= term_div;
          if (kk_q[0]) begin
            sum_q <= sum_q - $signed({3'b0, term_div});
          end else begin
            sum_q <= sum_q + $signed({3'b0, term_div});
          end
          if (kk_q == 3'd6) begin
            state_q <= S_CLAMP;
          end else begin
            kk_q    <= kk_q + 1'b1;
            state_q <= S_TM;
          end
        end
        S_CLAMP: begin
          if (sum_q < 0) begin
            dec_q <= '0;
          end else if (sum_q > OneQ30) begin
            dec_q <= 31'(OneQ30);
          end else begin
            dec_q <= sum_q[30:0];
          end
          kv_q    <= '0;
          state_q <= S_VM;
        end
        S_VM: state_q <= S_VM2;
        S_VM2: begin
          rec_q.vel[kv_q] <= sat16(rnd_shift(prod_q, 30));
          if (kv_q == 2'd2) begin
            kv_q    <= '0;
            state_q <= S_POS;
          end else begin
            kv_q    <= kv_q + 1'b1;
            state_q <= S_VM;
          end
        end
        S_POS: state_q <= S_POS2;
        S_POS2: begin
          rec_q.pos[kv_q] <= sat16(64'($signed(rec_q.pos[kv_q])) + rnd_shift(prod_q, 16));
          if (kv_q == 2'd2) begin
            kv_q    <= '0;
            state_q <= S_AGE;
          end else begin
            kv_q    <= kv_q + 1'b1;
            state_q <= S_POS;
          end
        end
        S_AGE: begin
          rec_q.age <= age_sum[16] ? 16'hffff : age_sum[15:0];
          state_q   <= S_LCHK;
        end
        S_LCHK: begin
          kl_q    <= '0;
          state_q <= keep ? S_AD : S_WB;
        end
        S_AD: begin
          if (!div_busy) begin
            a_q     <= (div_quo > DivW'(65536)) ? 17'd65536 : div_quo[16:0];
            state_q <= S_LM;
          end
        end
        S_LM: state_q <= S_LM2;
        S_LM2: begin
          if (kl_q[2] == 1'b0) begin
            rec_q.col[kl_q[1:0]] <= lsum[15:0];
          end else begin
            rec_q.sz <= lsum[15:0];
          end
          if (kl_q == 3'd4) begin
            state_q <= S_WB;
          end else begin
            kl_q    <= kl_q + 1'b1;
            state_q <= S_LM;
          end
        end
        S_WB: begin
          w_q <= w_nxt;
          i_q <= i_nxt;
          if (i_nxt == live_q) begin
            live_q       <= w_nxt;
            live_count_o <= 11'(w_nxt);
            out_valid_o  <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            rd_addr_q <= i_nxt[AW-1:0];
            state_q   <= S_TWAIT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the particle store integrator: scoreboard, drivers and checks.
`timescale 1ns / 1ps
module tb;
  import psi_pkg::*;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] step;
    logic [9:0]  idx;
    logic [47:0] pos;
    logic [47:0] vel;
    logic [47:0] ldg;
    logic [63:0] col;
    logic [63:0] ecol;
    logic [31:0] sizes;
  } stim_t;

  typedef struct {
    logic        accepted;
    logic [10:0] live;
    logic        rvalid;
    logic [47:0] pos;
    logic [63:0] col;
    logic [15:0] sz;
    logic [15:0] age;
  } result_t;

  typedef struct {
    logic [47:0] pos;
    logic [47:0] vel;
    logic [63:0] col;
    logic [63:0] ecol;
    logic [15:0] age;
    logic [15:0] life;
    logic [15:0] sz;
    logic [15:0] esz;
    logic [15:0] drag;
    logic [15:0] grav;
  } particle_t;

  class particle_scoreboard;
    particle_t store[1024];
    int        live_total;
    int        cap;
    int        errors;
    result_t   expected_q[$];

    function new();
      live_total = 0;
      cap = 1024;
      errors = 0;
    endfunction

    function longint round_shift(longint x, int n);
      longint unsigned mag;
      longint unsigned r;
      mag = (x < 0) ? longint'(-x) : x;
      r = (mag + (64'd1 << (n - 1))) >> n;
      return (x < 0) ? -longint'(r) : longint'(r);
    endfunction

    function logic [15:0] clip16(longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
    endfunction

    function longint sx(logic [15:0] v);
      longint s;
      s = $signed(v);
      return s;
    endfunction

    function longint decay_factor(longint unsigned x);
      longint unsigned term;
      longint sum;
      term = 64'd1 << 30;
      sum = longint'(term);
      for (int k = 1; k <= 6; k++) begin
        term = ((term * x) >> 30) / k;
        if (k % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
      return sum;
    endfunction

    function logic [15:0] blend(logic [15:0] c, logic [15:0] e, longint unsigned a);
      longint d;
      longint cv;
      d = longint'({48'd0, e}) - longint'({48'd0, c});
      cv = {48'd0, c};
      return 16'(cv + round_shift(d * longint'(a), 16));
    endfunction

    function void advance(logic [15:0] step);
      longint unsigned dt;
      longint unsigned dt12;
      longint unsigned a;
      longint unsigned age32;
      longint dec;
      longint vy;
      int w;
      particle_t q;
      dt = (step > MaxStep) ? 64'(MaxStep) : 64'(step);
      dt12 = (dt + 8) >> 4;
      w = 0;
      for (int i = 0; i < live_total; i++) begin
        q = store[i];
        vy = sx(q.vel[31:16]);
        q.vel[31:16] = clip16(vy + round_shift(sx(q.grav) * longint'(dt), 18));
        if (q.drag != 0) begin
          dec = decay_factor(64'(q.drag) * dt * 4);
          for (int k = 0; k < 3; k++)
            q.vel[16*k +: 16] = clip16(round_shift(sx(q.vel[16*k +: 16]) * dec, 30));
        end
        for (int k = 0; k < 3; k++)
          q.pos[16*k +: 16] = clip16(sx(q.pos[16*k +: 16])
                              + round_shift(sx(q.vel[16*k +: 16]) * longint'(dt), 16));
        age32 = 64'(q.age) + dt12;
        if (age32 > 65535) age32 = 65535;
        q.age = age32[15:0];
        if (q.life > q.age) begin
          a = (dt * 4096) / 64'(q.life - q.age);
          if (a > 65536) a = 65536;
          for (int k = 0; k < 4; k++)
            q.col[16*k +: 16] = blend(q.col[16*k +: 16], q.ecol[16*k +: 16], a);
          q.sz = blend(q.sz, q.esz, a);
        end
        if (q.age < q.life) begin
          store[w] = q;
          w++;
        end
      end
      live_total = w;
    endfunction

    function void note_input(stim_t s);
      result_t r;
      particle_t q;
      r = '{default: '0};
      case (s.op)
        OpTick: if (s.step != 0) advance(s.step);
        OpSpawn: begin
          if (live_total < cap && live_total < 1024) begin
            q.pos = s.pos;
            q.vel = s.vel;
            q.col = s.col;
            q.ecol = s.ecol;
            q.age = '0;
            q.life = (s.ldg[15:0] < MinLife) ? MinLife : s.ldg[15:0];
            q.sz = s.sizes[15:0];
            q.esz = s.sizes[31:16];
            q.drag = s.ldg[31:16];
            q.grav = s.ldg[47:32];
            store[live_total] = q;
            live_total++;
            r.accepted = 1'b1;
          end
        end
        OpRead: begin
          if (int'(s.idx) < live_total) begin
            r.rvalid = 1'b1;
            r.pos = store[s.idx].pos;
            r.col = store[s.idx].col;
            r.sz = store[s.idx].sz;
            r.age = store[s.idx].age;
          end
        end
        default: ;
      endcase
      r.live = 11'(live_total);
      expected_q = {expected_q, r};
    endfunction

    function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(result_t act);
      result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual live_count %0d",
                 $time, act.live);
        return;
      end
      e = expected_q.pop_front();
      compare("accepted", 64'(e.accepted), 64'(act.accepted));
      compare("live_count", 64'(e.live), 64'(act.live));
      compare("read_valid", 64'(e.rvalid), 64'(act.rvalid));
      compare("out_position", 64'(e.pos), 64'(act.pos));
      compare("out_color", e.col, act.col);
      compare("out_size", 64'(e.sz), 64'(act.sz));
      compare("out_age", 64'(e.age), 64'(act.age));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  operation_i;
  logic [15:0] step_time_i;
  logic [9:0]  read_index_i;
  logic [47:0] spawn_position_i, spawn_velocity_i, spawn_life_drag_gravity_i;
  logic [63:0] spawn_color_i, spawn_end_color_i;
  logic [31:0] spawn_sizes_i;
  logic        out_valid_o, out_ready_i;
  logic        accepted_o;
  logic [10:0] live_count_o;
  logic        read_valid_o;
  logic [47:0] out_position_o;
  logic [63:0] out_color_o;
  logic [15:0] out_size_o, out_age_o;

  particle_scoreboard particles = new();
  int sink_mode = 0;
  int sink_left = 0;
  int burst_left = 0;

  particle_store_integrator u_dut (.*);

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode <= $urandom_range(0, 3);
      sink_left <= $urandom_range(20, 200);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 7) != 0);
      default: out_ready_i <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      particles.check_result('{accepted_o, live_count_o, read_valid_o, out_position_o,
                               out_color_o, out_size_o, out_age_o});
  end

  task automatic send_item(stim_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    operation_i <= s.op;
    step_time_i <= s.step;
    read_index_i <= s.idx;
    spawn_position_i <= s.pos;
    spawn_velocity_i <= s.vel;
    spawn_life_drag_gravity_i <= s.ldg;
    spawn_color_i <= s.col;
    spawn_end_color_i <= s.ecol;
    spawn_sizes_i <= s.sizes;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    particles.note_input(s);
  endtask

  task automatic drain_and_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (particles.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cap(int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    particles.cap = value;
    @(posedge clk_i);
  endtask

  function automatic stim_t blank_stim(logic [1:0] op);
    stim_t s;
    s = '{default: '0};
    s.op = op;
    return s;
  endfunction

  function automatic stim_t spawn_stim(logic [47:0] pos, logic [47:0] vel, logic [15:0] life,
                                       logic [15:0] drag, logic [15:0] grav, logic [63:0] col,
                                       logic [63:0] ecol, logic [31:0] sizes);
    stim_t s;
    s = blank_stim(OpSpawn);
    s.pos = pos;
    s.vel = vel;
    s.ldg = {grav, drag, life};
    s.col = col;
    s.ecol = ecol;
    s.sizes = sizes;
    return s;
  endfunction

  function automatic stim_t random_stim(int live);
    stim_t s;
    int pick;
    s.pos = 48'({$urandom, $urandom});
    s.vel = 48'({$urandom, $urandom});
    s.col = {$urandom, $urandom};
    s.ecol = {$urandom, $urandom};
    s.sizes = $urandom;
    s.step = 16'($urandom);
    s.idx = 10'($urandom);
    s.ldg = 48'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 50) s.ldg[15:0] = 16'($urandom_range(0, 600));
    else if (pick < 90) s.ldg[15:0] = 16'($urandom_range(600, 8000));
    pick = $urandom_range(0, 99);
    if (pick < 40) s.ldg[31:16] = '0;
    else if (pick < 80) s.ldg[31:16] = 16'($urandom_range(1, 2000));
    pick = $urandom_range(0, 99);
    if (pick < 70) s.step = 16'($urandom_range(1, 2185));
    else if (pick < 80) s.step = '0;
    if (live > 0 && $urandom_range(0, 9) < 8) s.idx = 10'($urandom_range(0, live - 1));
    pick = $urandom_range(0, 99);
    if (pick < 5) s.op = 2'd3;
    else if (pick < 35 || live >= 24) s.op = (pick < 65) ? OpTick : OpRead;
    else if (pick < 70) s.op = OpSpawn;
    else s.op = (pick < 85) ? OpTick : OpRead;
    return s;
  endfunction

  initial begin
    stim_t s;
    int caps[7] = '{1, 16, 7, 1024, 12, 0, 24};
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    operation_i <= '0;
    step_time_i <= '0;
    read_index_i <= '0;
    spawn_position_i <= '0;
    spawn_velocity_i <= '0;
    spawn_life_drag_gravity_i <= '0;
    spawn_color_i <= '0;
    spawn_end_color_i <= '0;
    spawn_sizes_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cap(1024);
    send_item(blank_stim(OpRead));
    send_item(spawn_stim('0, '0, 16'd0, 16'd0, 16'd0, '0, '0, '0));
    send_item(spawn_stim({3{16'h7fff}}, {3{16'h7fff}}, 16'hffff, 16'hffff, 16'h8000,
                         {4{16'hffff}}, '0, 32'h0000ffff));
    send_item(spawn_stim({3{16'h8000}}, {3{16'h8000}}, 16'd204, 16'd0, 16'h7fff,
                         '0, {4{16'hffff}}, 32'hffff0000));
    send_item(spawn_stim({3{16'h0100}}, {3{16'hff00}}, 16'd4096, 16'd1, 16'd0,
                         {$urandom, $urandom}, {$urandom, $urandom}, $urandom));
    s = blank_stim(OpRead);
    for (int i = 0; i < 4; i++) begin
      s.idx = 10'(i);
      send_item(s);
    end
    s.idx = 10'd1023;
    send_item(s);
    send_item(blank_stim(2'd3));
    send_item(blank_stim(OpTick));
    s = blank_stim(OpTick);
    s.step = 16'hffff;
    send_item(s);
    s.step = 16'd1;
    send_item(s);
    s.step = 16'd2185;
    send_item(s);
    s = blank_stim(OpRead);
    for (int i = 0; i < 4; i++) begin
      s.idx = 10'(i);
      send_item(s);
    end
    drain_and_idle();
    write_cap(0);
    send_item(spawn_stim('0, '0, 16'd100, 16'd0, 16'd0, '0, '0, '0));
    drain_and_idle();

    foreach (caps[p]) begin
      write_cap(caps[p]);
      for (int n = 0; n < 80; n++) send_item(random_stim(particles.live_total));
      drain_and_idle();
    end

    repeat (50) @(posedge clk_i);
    if (particles.errors == 0 && particles.pending() == 0)
      $display("particle_store_integrator verification clean");
    else
      $display("particle_store_integrator verification failed");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("particle_store_integrator verification failed");
    $finish;
  end

endmodule
